// ----- rtl/core/ntm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the byte safety check for the digit display scanner.
// No dependencies.
package ntm_pkg;

    localparam int TUBE_COUNT = 4;
    localparam int IDX_W      = 2;

    localparam logic [7:0] ALL_OFF    = 8'h0F;
    localparam logic [3:0] BLANK_CODE = 4'hF;
    localparam logic [3:0] MAX_DIGIT  = 4'd9;
    localparam logic [7:0] MAX_HOUR   = 8'd23;
    localparam logic [7:0] MAX_MINUTE = 8'd59;
    localparam logic [7:0] MAX_INDIG  = 8'd9;
    localparam logic [15:0] SLOT_TICKS_RST = 16'd1000;
    localparam logic [15:0] TICKS_MAX      = 16'hFFFF;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_SLOT_TICKS = 1'b0;

    typedef enum logic [1:0] {
        FUNC_TIME    = 2'd0,
        FUNC_UNIFORM = 2'd1,
        FUNC_BLANK   = 2'd2,
        FUNC_TICK    = 2'd3
    } t_func;

    typedef struct packed {
        logic [7:0] shift_byte;
        logic       display_enabled;
        logic       rejected;
        logic       last;
    } t_result;

    // Safe: no anode active, or exactly one active with a valid BCD digit.
    function automatic logic byte_is_safe(input logic [7:0] v);
        logic [2:0] active;
        active = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < TUBE_COUNT && !v[i]) begin
                active = active + 3'd1;
            end
        end
        return (active == 3'd0) || ((active == 3'd1) && (v[7:4] <= MAX_DIGIT));
    endfunction

endpackage

// ----- rtl/core/nixie_tube_multiplexer_unit.sv -----
`timescale 1ns / 1ps
// Digit display scanner top level: input register, single-pass update, result queue.
// Depends on ntm_pkg.
//
// Takes one input beat per cycle while o_stall is low. Each beat is captured in an input
// register and processed from there once the queue has room; its results are registered
// in a two-entry result queue. Time, uniform and idle/non-due tick beats give no result
// and sustain one beat per cycle. Blank gives one result beat and a due tick gives two
// back-to-back result beats (blanking byte, then tube byte), so a stream of due ticks is
// limited by the single result port. The input stalls only while the queue lacks room
// for the pending beat's results.
module nixie_tube_multiplexer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_func,
    input  logic [7:0]                  i_hours,
    input  logic [7:0]                  i_minutes,
    input  logic [7:0]                  i_digit,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_shift_byte,
    output logic                        o_display_enabled,
    output logic                        o_rejected,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ntm_pkg::APB_AW-1:0]  paddr,
    input  logic [ntm_pkg::APB_DW-1:0]  pwdata,
    output logic [ntm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    // config
    logic [15:0] r_slot_ticks;

    // input register
    logic                 r_in_valid;
    ntm_pkg::t_func       r_func;
    logic [7:0]           r_hours, r_minutes, r_digit;

    // display state
    logic [3:0]                r_digits [4];
    logic [3:0]                n_digits [4];
    logic                      r_buf_valid, n_buf_valid;
    logic                      r_scan_on, n_scan_on;
    logic [ntm_pkg::IDX_W-1:0] r_index, n_index;
    logic [15:0]               r_ticks, n_ticks;
    logic                      r_first, n_first;
    logic                      r_oe, n_oe;

    // result queue
    ntm_pkg::t_result r_q [2];
    logic             r_head;
    logic [1:0]       r_cnt;

    logic             fire, accept, pop;
    logic [1:0]       n_res;
    ntm_pkg::t_result res0, res1;

    logic [7:0] h_units, m_units;
    logic [1:0] h_tens;
    logic [2:0] m_tens;
    logic [3:0] cur_d;
    logic [7:0] bv, tv;
    logic       ok0, ok1, okb;
    logic [15:0] inc;
    logic       due;
    logic       wp0;
    logic       cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ntm_pkg::REG_SLOT_TICKS);
    assign prdata = (paddr[2] == ntm_pkg::REG_SLOT_TICKS) ? {16'd0, r_slot_ticks} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ticks <= ntm_pkg::SLOT_TICKS_RST;
        end else if (cfg_wr) begin
            r_slot_ticks <= pwdata[15:0];
        end
    end

    // handshakes; a slot freed by this cycle's pop counts as room
    assign accept  = i_valid && !o_stall;
    assign o_stall = r_in_valid && !fire;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign fire    = r_in_valid &&
                     ({1'b0, n_res} <= (3'd2 - {1'b0, r_cnt} + {2'd0, pop}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func    <= ntm_pkg::t_func'(i_func);
            r_hours   <= i_hours;
            r_minutes <= i_minutes;
            r_digit   <= i_digit;
        end
    end

    // digit split for in-range time values
    always_comb begin
        if (r_hours >= 8'd20) begin
            h_tens = 2'd2;
        end else if (r_hours >= 8'd10) begin
            h_tens = 2'd1;
        end else begin
            h_tens = 2'd0;
        end
        h_units = r_hours - (8'd10 * {6'd0, h_tens});
        if (r_minutes >= 8'd50) begin
            m_tens = 3'd5;
        end else if (r_minutes >= 8'd40) begin
            m_tens = 3'd4;
        end else if (r_minutes >= 8'd30) begin
            m_tens = 3'd3;
        end else if (r_minutes >= 8'd20) begin
            m_tens = 3'd2;
        end else if (r_minutes >= 8'd10) begin
            m_tens = 3'd1;
        end else begin
            m_tens = 3'd0;
        end
        m_units = r_minutes - (8'd10 * {5'd0, m_tens});
    end

    // scan bytes for the current tube
    always_comb begin
        cur_d = r_digits[r_index];
        bv    = ntm_pkg::ALL_OFF;
        tv    = ntm_pkg::ALL_OFF;
        if (cur_d <= ntm_pkg::MAX_DIGIT) begin
            bv = ntm_pkg::ALL_OFF | {cur_d, 4'd0};
            tv = (ntm_pkg::ALL_OFF & ~(8'd1 << r_index)) | {cur_d, 4'd0};
        end
        ok0 = ntm_pkg::byte_is_safe(bv);
        ok1 = ntm_pkg::byte_is_safe(tv);
        okb = ntm_pkg::byte_is_safe(ntm_pkg::ALL_OFF);
        inc = (r_ticks == ntm_pkg::TICKS_MAX) ? r_ticks : r_ticks + 16'd1;
        due = r_first || (inc >= r_slot_ticks);
    end

    always_comb begin
        n_digits    = r_digits;
        n_buf_valid = r_buf_valid;
        n_scan_on   = r_scan_on;
        n_index     = r_index;
        n_ticks     = r_ticks;
        n_first     = r_first;
        n_oe        = r_oe;
        n_res       = 2'd0;
        res0        = '0;
        res1        = '0;
        case (r_func)
            ntm_pkg::FUNC_TIME: begin
                if (r_hours <= ntm_pkg::MAX_HOUR && r_minutes <= ntm_pkg::MAX_MINUTE) begin
                    n_digits[0] = (h_tens == 2'd0) ? ntm_pkg::BLANK_CODE : {2'd0, h_tens};
                    n_digits[1] = h_units[3:0];
                    n_digits[2] = {1'b0, m_tens};
                    n_digits[3] = m_units[3:0];
                    n_buf_valid = 1'b1;
                    if (!r_scan_on) begin
                        n_scan_on = 1'b1;
                        n_index   = '0;
                        n_first   = 1'b1;
                    end
                end
            end
            ntm_pkg::FUNC_UNIFORM: begin
                if (r_digit <= ntm_pkg::MAX_INDIG) begin
                    for (int i = 0; i < 4; i++) begin
                        n_digits[i] = r_digit[3:0];
                    end
                    n_buf_valid = 1'b1;
                    if (!r_scan_on) begin
                        n_scan_on = 1'b1;
                        n_index   = '0;
                        n_first   = 1'b1;
                    end
                end
            end
            ntm_pkg::FUNC_BLANK: begin
                n_scan_on = 1'b0;
                n_oe      = okb ? r_oe : 1'b0;
                n_res     = 2'd1;
                res0      = '{shift_byte: ntm_pkg::ALL_OFF, display_enabled: n_oe,
                              rejected: !okb, last: 1'b1};
            end
            ntm_pkg::FUNC_TICK: begin
                if (r_scan_on && r_buf_valid) begin
                    if (!r_first) begin
                        n_ticks = inc;
                    end
                    if (due) begin
                        n_ticks = '0;
                        n_first = 1'b0;
                        n_oe    = ok1;
                        n_res   = 2'd2;
                        res0    = '{shift_byte: ok0 ? bv : ntm_pkg::ALL_OFF,
                                    display_enabled: 1'b1, rejected: !ok0, last: 1'b0};
                        res1    = '{shift_byte: ok1 ? tv : ntm_pkg::ALL_OFF,
                                    display_enabled: ok1, rejected: !ok1, last: 1'b1};
                        // advance modulo the tube count
                        n_index = (r_index == ntm_pkg::IDX_W'(ntm_pkg::TUBE_COUNT - 1)) ?
                                  '0 : r_index + 1'b1;
                    end
                end
            end
            default: begin
                n_res = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_digits[i] <= ntm_pkg::BLANK_CODE;
            end
            r_buf_valid <= 1'b0;
            r_scan_on   <= 1'b0;
            r_index     <= '0;
            r_ticks     <= '0;
            r_first     <= 1'b1;
            r_oe        <= 1'b0;
        end else if (fire) begin
            r_digits    <= n_digits;
            r_buf_valid <= n_buf_valid;
            r_scan_on   <= n_scan_on;
            r_index     <= n_index;
            r_ticks     <= n_ticks;
            r_first     <= n_first;
            r_oe        <= n_oe;
        end
    end

    // result queue: up to two writes, one pop per cycle
    assign wp0 = r_head ^ r_cnt[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_head <= r_head ^ pop;
            r_cnt  <= r_cnt + (fire ? n_res : 2'd0) - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_res != 2'd0) begin
            r_q[wp0] <= res0;
        end
        if (fire && n_res == 2'd2) begin
            r_q[~wp0] <= res1;
        end
    end

    assign o_shift_byte      = r_q[r_head].shift_byte;
    assign o_display_enabled = r_q[r_head].display_enabled;
    assign o_rejected        = r_q[r_head].rejected;
    assign o_last            = r_q[r_head].last;

endmodule

// ----- rtl/core/ntm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the digit display scanner, bound to the top level.
// Depends on nixie_tube_multiplexer_unit.
module ntm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_shift_byte,
    input logic       o_display_enabled,
    input logic       o_last
);

    // blanking beat of a due tick: anodes off, output enabled
    a_blank_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_display_enabled && (o_shift_byte[3:0] == 4'hF))
        else $error("blanking beat malformed");

    // tube beat follows its blanking beat in the next cycle
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && !i_stall |=> o_valid && o_last)
        else $error("tube beat did not follow blanking beat");

    // never light more than one tube
    a_one_anode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones(~o_shift_byte[3:0]) <= 1)
        else $error("more than one anode active");

    // a lit tube carries a valid BCD digit
    a_lit_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_shift_byte[3:0] != 4'hF) |-> o_shift_byte[7:4] <= 4'd9)
        else $error("lit tube with invalid digit");

endmodule

bind nixie_tube_multiplexer_unit ntm_checker u_ntm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_shift_byte      (o_shift_byte),
    .o_display_enabled (o_display_enabled),
    .o_last            (o_last)
);
